### hdl/landmark_refcount_table_assert.svh
// Assertion macros for the landmark refcount table checker.
// No dependencies.
`ifndef LANDMARK_REFCOUNT_TABLE_ASSERT_SVH
`define LANDMARK_REFCOUNT_TABLE_ASSERT_SVH
// Implication checked on every edge outside reset.
`define LRT_ASSERT_IMP(lbl, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("lrt check failed");
// Next-cycle implication.
`define LRT_ASSERT_NEXT(lbl, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("lrt check failed");
`endif

### hdl/lrt_pkg.sv
// Package for the landmark refcount table: widths, codes, shared types.
// No dependencies.
package lrt_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int POS_FRAC_BITS = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W = 63;
  localparam int CNT_W = 16;
  localparam int POS_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] ACT_ADD_AVG = 2'd0;
  localparam logic [1:0] ACT_ADD_CNT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_SCAN = 2'd3;

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DECR = 3'd2;
  localparam logic [2:0] ST_ERASED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;
  localparam logic [2:0] ST_SCAN_ENTRY = 3'd6;
  localparam logic [2:0] ST_SCAN_EMPTY = 3'd7;

  // Divider handshake between sequencer and divider.
  typedef struct packed {
    logic start;
    logic signed [48:0] num;
    logic [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [POS_W-1:0] quot;
  } div_rsp_t;
endpackage

### hdl/lrt_divider.sv
// Serial restoring divider, signed numerator by unsigned divisor, truncating.
// Depends on lrt_pkg.
module lrt_divider import lrt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [48:0] rem_q;
  logic [48:0] quo;
  logic [16:0] den;
  logic        neg;
  logic        busy;
  logic        done_q;
  logic [5:0]  cnt;
  logic [49:0] trial;
  logic [48:0] mag;
  logic [48:0] qfin;

  assign mag = req.num[48] ? 49'(-req.num) : 49'(req.num);
  assign trial = {rem_q, quo[48]} - {33'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy && (cnt == 6'd0);
      if (req.start) begin
        busy <= 1'b1;
        rem_q <= '0;
        quo <= mag;
        den <= req.den;
        neg <= req.num[48];
        cnt <= 6'd48;
      end else if (busy) begin
        // one quotient bit per cycle
        if (!trial[49]) begin
          rem_q <= trial[48:0];
          quo <= {quo[47:0], 1'b1};
        end else begin
          rem_q <= {rem_q[47:0], quo[48]};
          quo <= {quo[47:0], 1'b0};
        end
        if (cnt == 6'd0) busy <= 1'b0;
        cnt <= cnt - 6'd1;
      end
    end
  end

  assign qfin = neg ? 49'(-quo) : quo;
  assign rsp = {done_q, qfin[POS_W-1:0]};
endmodule

### hdl/landmark_refcount_table.sv
// Landmark refcount table, top level: table memories and sequencer.
// Depends on lrt_pkg and lrt_divider.
//
// Usage: items arrive on the s_axis channel (tdata: action, lm_id, pos_x,
// pos_y, pos_z, min_views). Results leave on m_axis; tlast marks the last
// result of an item. The block takes one item at a time and drops s_tready
// from the transfer of an item until its last result has transferred.
// Operation: a lookup reads and compares one entry at a time (S_RD, then
// S_CMP), so a miss loads its result once every occupied entry has been
// compared. An averaging hit adds three divisions on the shared serial
// divider, one per axis. An erase moves each later entry down, reading it in
// S_SHRD and writing it in S_SHWR. A scan reads each entry in turn and takes
// each qualifying entry through S_SCNO; each result is held back until the
// next one is found, so tlast lands on the final one.
// Throughput: one item at a time; the block returns to S_IDLE before the next.
// Reset: occupancy clears to zero, so the table is empty; the memories
// themselves are not cleared. When the receiver stalls, the result register
// holds and the sequencer waits before it loads another result.
module landmark_refcount_table import lrt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[1:0], lm_id[64:2], pos_x[96:65], pos_y[128:97], pos_z[160:129],
  // min_views[176:161], zero fill
  input  logic [183:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], out_id[65:3], out_count[81:66], out_x[113:82],
  // out_y[145:114], out_z[177:146], zero fill
  output logic [183:0] m_tdata,
  output logic         m_tlast
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RD     = 10'b0000000010,
    S_CMP    = 10'b0000000100,
    S_DIV    = 10'b0000001000,
    S_DIVW   = 10'b0000010000,
    S_WB     = 10'b0000100000,
    S_SHRD   = 10'b0001000000,
    S_SHWR   = 10'b0010000000,
    S_OUT    = 10'b0100000000,
    S_SCNO   = 10'b1000000000
  } state_t;

  state_t state;

  // memories
  logic [ID_W-1:0]  mem_id  [TABLE_DEPTH];
  logic [CNT_W-1:0] mem_cnt [TABLE_DEPTH];
  logic [3*POS_W-1:0] mem_pos [TABLE_DEPTH];
  logic [IDX_W-1:0] rd_addr;
  logic [ID_W-1:0]  rd_id;
  logic [CNT_W-1:0] rd_cnt;
  logic [3*POS_W-1:0] rd_pos;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ID_W-1:0]  wr_id;
  logic [CNT_W-1:0] wr_cnt;
  logic [3*POS_W-1:0] wr_pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr] <= wr_id;
      mem_cnt[wr_addr] <= wr_cnt;
      mem_pos[wr_addr] <= wr_pos;
    end
    rd_id <= mem_id[rd_addr];
    rd_cnt <= mem_cnt[rd_addr];
    rd_pos <= mem_pos[rd_addr];
  end

  // latched item
  logic [1:0]        act;
  logic [ID_W-1:0]   key;
  logic [3*POS_W-1:0] obs;
  logic [CNT_W-1:0]  minv;
  logic [OCC_W-1:0]  occ;
  logic [OCC_W-1:0]  ptr;
  logic [IDX_W-1:0]  hit_idx;
  logic [CNT_W-1:0]  hit_cnt;
  logic [3*POS_W-1:0] newpos;
  logic [1:0]        axis;
  logic              found_any;
  // scan entry waiting for its successor
  logic [ID_W-1:0]   pend_id;
  logic [CNT_W-1:0]  pend_cnt;
  logic [3*POS_W-1:0] pend_pos;

  div_req_t dreq;
  div_rsp_t drsp;
  lrt_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [POS_W-1:0] old_c;
  logic signed [POS_W-1:0] obs_c;
  logic signed [48:0] prod;
  always_comb begin
    case (axis)
      2'd0: begin old_c = rd_pos[31:0]; obs_c = obs[31:0]; end
      2'd1: begin old_c = rd_pos[63:32]; obs_c = obs[63:32]; end
      default: begin old_c = rd_pos[95:64]; obs_c = obs[95:64]; end
    endcase
  end
  // numerator c*old + new fits in 49 bits
  assign prod = $signed({1'b0, hit_cnt}) * 49'(old_c) + 49'(obs_c);

  assign s_tready = (state == S_IDLE);

  always_comb begin
    dreq.start = (state == S_DIV);
    dreq.num = prod;
    dreq.den = {1'b0, hit_cnt} + 17'd1;
    rd_addr = ptr[IDX_W-1:0];
  end

  task automatic put_out(input logic [2:0] st, input logic [ID_W-1:0] id,
                         input logic [CNT_W-1:0] c, input logic [3*POS_W-1:0] p,
                         input logic lst);
    m_tdata <= {6'd0, p, c, id, st};
    m_tlast <= lst;
    m_tvalid <= 1'b1;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ <= '0;
      wr_en <= 1'b0;
      m_tvalid <= 1'b0;
      m_tlast <= 1'b0;
    end else begin
      // write strobe for the insert, decrement, update and shift steps
      wr_en <= (state == S_WB) || (state == S_SHWR) ||
               (state == S_RD && ptr >= occ && act != ACT_SCAN && act != ACT_REMOVE &&
                occ < OCC_W'(TABLE_DEPTH)) ||
               (state == S_CMP && act == ACT_REMOVE && rd_id == key &&
                rd_cnt > CNT_W'(1));
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act <= s_tdata[1:0];
            key <= s_tdata[64:2];
            obs <= s_tdata[160:65];
            minv <= s_tdata[176:161];
            ptr <= '0;
            found_any <= 1'b0;
            state <= S_RD;
          end
        end
        S_RD: begin
          // address ptr presented; data arrives next cycle
          if (ptr >= occ) begin
            if (act == ACT_SCAN) begin
              // flush the held entry as the last one, or report an empty scan
              if (!m_tvalid) begin
                if (found_any) put_out(ST_SCAN_ENTRY, pend_id, pend_cnt, pend_pos, 1'b1);
                else put_out(ST_SCAN_EMPTY, '0, '0, '0, 1'b1);
                state <= S_OUT;
              end
            end else if (act == ACT_REMOVE) begin
              put_out(ST_NOTFOUND, key, '0, '0, 1'b1);
              state <= S_OUT;
            end else if (occ >= OCC_W'(TABLE_DEPTH)) begin
              put_out(ST_FULL, key, '0, '0, 1'b1);
              state <= S_OUT;
            end else begin
              wr_addr <= occ[IDX_W-1:0];
              wr_id <= key;
              wr_cnt <= CNT_W'(1);
              wr_pos <= obs;
              occ <= occ + OCC_W'(1);
              put_out(ST_INSERTED, key, CNT_W'(1), obs, 1'b1);
              state <= S_OUT;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (act == ACT_SCAN) begin
            if (rd_cnt >= minv) begin
              state <= S_SCNO;
            end else begin
              ptr <= ptr + OCC_W'(1);
              state <= S_RD;
            end
          end else if (rd_id == key) begin
            hit_idx <= ptr[IDX_W-1:0];
            hit_cnt <= rd_cnt;
            newpos <= rd_pos;
            axis <= 2'd0;
            if (act == ACT_REMOVE) begin
              if (rd_cnt > CNT_W'(1)) begin
                wr_addr <= ptr[IDX_W-1:0];
                wr_id <= rd_id;
                wr_cnt <= rd_cnt - CNT_W'(1);
                wr_pos <= rd_pos;
                put_out(ST_DECR, key, rd_cnt - CNT_W'(1), rd_pos, 1'b1);
                state <= S_OUT;
              end else begin
                put_out(ST_ERASED, key, '0, rd_pos, 1'b1);
                ptr <= ptr + OCC_W'(1);
                state <= S_SHRD;
              end
            end else if (act == ACT_ADD_AVG) begin
              state <= S_DIV;
            end else begin
              state <= S_WB;
            end
          end else begin
            ptr <= ptr + OCC_W'(1);
            state <= S_RD;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (drsp.done) begin
            case (axis)
              2'd0: newpos[31:0] <= drsp.quot;
              2'd1: newpos[63:32] <= drsp.quot;
              default: newpos[95:64] <= drsp.quot;
            endcase
            if (axis == 2'd2) begin
              state <= S_WB;
            end else begin
              axis <= axis + 2'd1;
              state <= S_DIV;
            end
          end
        end
        S_WB: begin
          wr_addr <= hit_idx;
          wr_id <= key;
          wr_cnt <= (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + CNT_W'(1);
          wr_pos <= newpos;
          put_out(ST_UPDATED, key,
                  (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + CNT_W'(1), newpos, 1'b1);
          state <= S_OUT;
        end
        S_SHRD: begin
          // ptr is the source entry; read it, write at ptr-1
          if (ptr >= occ) begin
            occ <= occ - OCC_W'(1);
            state <= S_OUT;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          wr_addr <= IDX_W'(ptr - OCC_W'(1));
          wr_id <= rd_id;
          wr_cnt <= rd_cnt;
          wr_pos <= rd_pos;
          ptr <= ptr + OCC_W'(1);
          state <= S_SHRD;
        end
        S_SCNO: begin
          // qualifying entry on the read port: once the output is free, send
          // the held entry, hold this one and advance
          if (!m_tvalid) begin
            if (found_any) put_out(ST_SCAN_ENTRY, pend_id, pend_cnt, pend_pos, 1'b0);
            pend_id <= rd_id;
            pend_cnt <= rd_cnt;
            pend_pos <= rd_pos;
            found_any <= 1'b1;
            ptr <= ptr + OCC_W'(1);
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (m_tvalid && m_tready) state <= S_IDLE;
          else if (!m_tvalid) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/lrt_checker.sv
// Port-level checker for the landmark refcount table, with its bind.
// Depends on landmark_refcount_table_assert.svh.
`include "landmark_refcount_table_assert.svh"
module lrt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [183:0] m_tdata,
  input logic         m_tlast
);
  `LRT_ASSERT_NEXT(a_hold, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `LRT_ASSERT_IMP(a_busy, rst, m_tvalid && m_tlast, !s_tready)
  `LRT_ASSERT_IMP(a_last, rst, m_tvalid && m_tdata[2:1] != 2'b11, m_tlast)
  `LRT_ASSERT_NEXT(a_take, rst, s_tvalid && s_tready, !s_tready)
endmodule

bind landmark_refcount_table lrt_checker u_chk (.*);

### bench/landmark_refcount_table_tb.sv
// Self-checking bench for the landmark refcount table: queued stimulus, handshake
// driver and monitor, and a table predictor that holds the expected results.
// Depends on lrt_pkg and the landmark_refcount_table RTL.
`timescale 1ns / 1ps

module landmark_refcount_table_tb import lrt_pkg::*; ();

  typedef struct {
    logic [1:0]              action;
    logic [ID_W-1:0]         lm_id;
    logic signed [POS_W-1:0] pos [3];
    logic [CNT_W-1:0]        min_views;
    bit                      burst;   // no idle gap after this item
  } lm_cmd_t;

  typedef struct {
    logic [2:0]              status;
    logic [ID_W-1:0]         id;
    logic [CNT_W-1:0]        count;
    logic signed [POS_W-1:0] pos [3];
    logic                    last;
  } lm_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [183:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [183:0] m_tdata;
  logic         m_tlast;

  landmark_refcount_table dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lm_cmd_t cmd_q [$];
  lm_res_t landmark_expect_q [$];
  int      errors = 0;

  // Shadow of the landmark table.
  logic [ID_W-1:0]         tbl_id  [TABLE_DEPTH];
  logic [CNT_W-1:0]        tbl_cnt [TABLE_DEPTH];
  logic signed [POS_W-1:0] tbl_pos [TABLE_DEPTH][3];
  int                      tbl_occ = 0;

  function automatic lm_res_t make_res(logic [2:0] st, logic [ID_W-1:0] id,
                                       logic [CNT_W-1:0] cnt, int idx, logic last);
    lm_res_t r;
    r.status = st;
    r.id = id;
    r.count = cnt;
    for (int k = 0; k < 3; k++) r.pos[k] = (idx < 0) ? '0 : tbl_pos[idx][k];
    r.last = last;
    return r;
  endfunction

  // Append one expected result.
  task automatic add_expect(lm_res_t r);
    landmark_expect_q.insert(landmark_expect_q.size(), r);
  endtask

  // Apply one accepted item to the shadow table and queue its results.
  task automatic apply_landmark_cmd(lm_cmd_t c);
    int idx;
    int n;
    longint num;
    longint cnt_l;
    idx = -1;
    n = 0;
    if (c.action == ACT_SCAN) begin
      for (int i = 0; i < tbl_occ; i++)
        if (tbl_cnt[i] >= c.min_views) begin
          add_expect(make_res(ST_SCAN_ENTRY, tbl_id[i], tbl_cnt[i], i, 1'b0));
          n++;
        end
      if (n == 0) add_expect(make_res(ST_SCAN_EMPTY, '0, '0, -1, 1'b1));
      else landmark_expect_q[landmark_expect_q.size()-1].last = 1'b1;
      return;
    end
    for (int i = 0; i < tbl_occ; i++)
      if (idx < 0 && tbl_id[i] == c.lm_id) idx = i;
    if (c.action == ACT_REMOVE) begin
      if (idx < 0) begin
        add_expect(make_res(ST_NOTFOUND, c.lm_id, '0, -1, 1'b1));
      end else if (tbl_cnt[idx] > 1) begin
        tbl_cnt[idx]--;
        add_expect(make_res(ST_DECR, c.lm_id, tbl_cnt[idx], idx, 1'b1));
      end else begin
        add_expect(make_res(ST_ERASED, c.lm_id, '0, idx, 1'b1));
        // Close the gap: shift later entries down by one.
        for (int j = idx; j + 1 < tbl_occ; j++) begin
          tbl_id[j] = tbl_id[j+1];
          tbl_cnt[j] = tbl_cnt[j+1];
          for (int k = 0; k < 3; k++) tbl_pos[j][k] = tbl_pos[j+1][k];
        end
        tbl_occ--;
      end
      return;
    end
    if (idx >= 0) begin
      cnt_l = longint'(tbl_cnt[idx]);
      if (c.action == ACT_ADD_AVG)
        for (int k = 0; k < 3; k++) begin
          num = cnt_l * longint'(tbl_pos[idx][k]) + longint'(c.pos[k]);
          tbl_pos[idx][k] = POS_W'(num / (cnt_l + 1));
        end
      // Hold the count at its ceiling.
      if (tbl_cnt[idx] != CNT_MAX) tbl_cnt[idx]++;
      add_expect(make_res(ST_UPDATED, c.lm_id, tbl_cnt[idx], idx, 1'b1));
    end else if (tbl_occ >= TABLE_DEPTH) begin
      add_expect(make_res(ST_FULL, c.lm_id, '0, -1, 1'b1));
    end else begin
      tbl_id[tbl_occ] = c.lm_id;
      tbl_cnt[tbl_occ] = CNT_W'(1);
      for (int k = 0; k < 3; k++) tbl_pos[tbl_occ][k] = c.pos[k];
      add_expect(make_res(ST_INSERTED, c.lm_id, 16'd1, tbl_occ, 1'b1));
      tbl_occ++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: present queued items, predict each one at its transfer.
  lm_cmd_t cur_cmd;
  int      send_gap = 0;
  bit      quiet_send = 1'b0;

  always @(posedge clk) begin
    logic nxt_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_landmark_cmd(cur_cmd);
        nxt_valid = 1'b0;
        if ($urandom_range(0, 49) == 0) quiet_send = ~quiet_send;
        send_gap = (cur_cmd.burst || quiet_send) ? 0 : pick_gap();
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          s_tdata <= {7'b0, cur_cmd.min_views, cur_cmd.pos[2], cur_cmd.pos[1],
                      cur_cmd.pos[0], cur_cmd.lm_id, cur_cmd.action};
          nxt_valid = 1'b1;
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    if (errors < 20)
      $display("mismatch %s: expected %h got %h at %0t", field, want, got, $realtime);
    errors++;
  endtask

  // Monitor: check each result transfer against the oldest expectation.
  int  stall_cnt = 0;
  bit  quiet_recv = 1'b0;

  always @(posedge clk) begin
    lm_res_t w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (landmark_expect_q.size() == 0) begin
          report("unexpected result", '0, m_tdata[63:0]);
        end else begin
          w = landmark_expect_q.pop_front();
          if (m_tdata[2:0] !== w.status) report("status", w.status, m_tdata[2:0]);
          if (m_tdata[65:3] !== w.id) report("out_id", w.id, m_tdata[65:3]);
          if (m_tdata[81:66] !== w.count) report("out_count", w.count, m_tdata[81:66]);
          if (m_tdata[113:82] !== w.pos[0]) report("out_x", w.pos[0], m_tdata[113:82]);
          if (m_tdata[145:114] !== w.pos[1]) report("out_y", w.pos[1], m_tdata[145:114]);
          if (m_tdata[177:146] !== w.pos[2]) report("out_z", w.pos[2], m_tdata[177:146]);
          if (m_tlast !== w.last) report("tlast", w.last, m_tlast);
        end
      end
      if ($urandom_range(0, 99) == 0) quiet_recv = ~quiet_recv;
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_tready <= 1'b0;
      end else if (!quiet_recv && $urandom_range(0, 3) == 0) begin
        stall_cnt = pick_gap();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_cmd(logic [1:0] act, logic [ID_W-1:0] id, logic [31:0] x,
                          logic [31:0] y, logic [31:0] z, logic [CNT_W-1:0] mv,
                          bit burst = 1'b0);
    lm_cmd_t c;
    c.action = act;
    c.lm_id = id;
    c.pos[0] = x;
    c.pos[1] = y;
    c.pos[2] = z;
    c.min_views = mv;
    c.burst = burst;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  function automatic logic [31:0] rnd_pos();
    return $urandom();
  endfunction

  logic [ID_W-1:0] id_pool [72];
  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [ID_W-1:0] ID_SAT = 63'h2A5A_0F0F_1234_5678;

  initial begin
    logic [1:0] act;
    int         r;
    id_pool[0] = '0;
    id_pool[1] = ID_MAX;
    for (int i = 2; i < 72; i++) id_pool[i] = ID_W'({$urandom(), $urandom()});

    // Directed: empty scan, miss on remove, field extremes, shifts on erase.
    push_cmd(ACT_SCAN, '0, '0, '0, '0, 16'd0);
    push_cmd(ACT_REMOVE, ID_MAX, 32'h7fff_ffff, 32'h8000_0000, '1, '1);
    push_cmd(ACT_ADD_AVG, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
    push_cmd(ACT_ADD_CNT, ID_MAX, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    push_cmd(ACT_ADD_AVG, 63'd12345, 32'h0001_8000, 32'hffff_0000, 32'd7, '0);
    push_cmd(ACT_ADD_AVG, '0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    push_cmd(ACT_ADD_AVG, ID_MAX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    push_cmd(ACT_ADD_AVG, 63'd12345, 32'hffff_fffd, 32'h0000_0005, 32'hffff_ffff, '0);
    push_cmd(ACT_ADD_CNT, 63'd12345, '1, '1, '1, '0);
    push_cmd(ACT_SCAN, '0, '0, '0, '0, 16'd0);
    push_cmd(ACT_SCAN, '0, '0, '0, '0, 16'd3);
    push_cmd(ACT_SCAN, '0, '0, '0, '0, 16'hffff);
    push_cmd(ACT_REMOVE, '0, '0, '0, '0, '0);
    push_cmd(ACT_REMOVE, '0, '0, '0, '0, '0);
    push_cmd(ACT_SCAN, '0, '0, '0, '0, 16'd1);
    push_cmd(ACT_REMOVE, 63'd12345, '0, '0, '0, '0);
    push_cmd(ACT_REMOVE, 63'd99, '0, '0, '0, '0);

    // Back-to-back adds and averaging on one id, then scan it and decrement it with a remove.
    push_cmd(ACT_ADD_AVG, ID_SAT, 32'h0010_0000, 32'hfff0_0000, 32'd3, '0, 1'b1);
    push_cmd(ACT_ADD_CNT, ID_SAT, '0, '0, '0, '0, 1'b1);
    push_cmd(ACT_ADD_AVG, ID_SAT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0001, '0);
    push_cmd(ACT_ADD_CNT, ID_SAT, '0, '0, '0, '0);
    push_cmd(ACT_SCAN, '0, '0, '0, '0, 16'hffff);
    push_cmd(ACT_REMOVE, ID_SAT, '0, '0, '0, '0);

    // Random: mostly pool ids so hits, fills and erases happen; add-heavy
    // first to reach a full table, then mixed.
    for (int n = 0; n < 437; n++) begin
      r = $urandom_range(0, 99);
      if (r < ((n < 200) ? 75 : 45))
        act = ($urandom_range(0, 1) == 0) ? ACT_ADD_AVG : ACT_ADD_CNT;
      else if (r < 88) act = ACT_REMOVE;
      else act = ACT_SCAN;
      push_cmd(act,
               ($urandom_range(0, 9) == 0) ? ID_W'({$urandom(), $urandom()})
                                           : id_pool[$urandom_range(0, 71)],
               rnd_pos(), rnd_pos(), rnd_pos(),
               ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6)));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (cmd_q.size() == 0 && !s_tvalid && landmark_expect_q.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && landmark_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/lrt_pkg.sv
hdl/lrt_divider.sv
hdl/landmark_refcount_table.sv
hdl/lrt_checker.sv
bench/landmark_refcount_table_tb.sv
